@@ rtl/core/paged_byte_memory_multibyte_access_top_macros.svh @@
// Assertion macros shared by the paged byte memory modules.
`ifndef PAGED_BYTE_MEMORY_MULTIBYTE_ACCESS_TOP_MACROS_SVH
`define PAGED_BYTE_MEMORY_MULTIBYTE_ACCESS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PBMA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PBMA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PBMA_ASSERT_IMP(name, ante, cons, msg)
`define PBMA_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

@@ rtl/core/pbma_pkg.sv @@
// Types and constants shared by the paged byte memory modules.
package pbma_pkg;

  localparam int DATA_W = 64;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

endpackage

@@ rtl/core/pbma_ctrl.sv @@
// Controller state machine that sequences one access byte by byte.
`include "paged_byte_memory_multibyte_access_top_macros.svh"
module pbma_ctrl #(
  parameter int MAX_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pbma_pkg::LEN_W-1:0] num_bytes,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pbma_pkg::cmd_t            cmd
);
  import pbma_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] len_in;
  logic             out_free;

  assign len_in   = (num_bytes > MAX_LEN) ? CNT_W'(MAX_BYTES) : CNT_W'(num_bytes);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.step   = (state == S_RUN);
    cmd.finish = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            remaining <= len_in;
            state     <= (len_in == '0) ? S_FLUSH : S_RUN;
          end
        end
        S_RUN: begin
          remaining <= remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PBMA_ASSERT_IMP(a_run_has_bytes, state == S_RUN, remaining != '0, "byte step with no bytes left")
  `PBMA_ASSERT_IMP(a_finish_free, cmd.finish, out_free, "result loaded over an untaken result")
  `PBMA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second transfer taken while busy")

endmodule

@@ rtl/core/pbma_datapath.sv @@
// Datapath with the byte store, the page valid bits and the result registers.
`include "paged_byte_memory_multibyte_access_top_macros.svh"
module pbma_datapath #(
  parameter int ADDR_W           = 16,
  parameter int PAGE_OFFSET_BITS = 8,
  parameter int MAX_BYTES        = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pbma_pkg::cmd_t              cmd,
  input  logic                        opcode,
  input  logic [15:0]                 byte_address,
  input  logic [pbma_pkg::DATA_W-1:0] write_data,
  output logic [pbma_pkg::DATA_W-1:0] read_data,
  output logic                        page_error
);
  import pbma_pkg::*;

  localparam int DEPTH      = 1 << ADDR_W;
  localparam int PAGE_BITS  = (ADDR_W > PAGE_OFFSET_BITS) ? (ADDR_W - PAGE_OFFSET_BITS) : 0;
  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int PIDX_W     = (PAGE_BITS > 0) ? PAGE_BITS : 1;
  localparam int IDX_W      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [BYTE_W-1:0]     mem [DEPTH];
  logic [BYTE_W-1:0]     mem_q;
  logic [PAGE_COUNT-1:0] page_valid;

  logic                  op;
  logic [ADDR_W-1:0]     addr;
  logic [DATA_W-1:0]     wdata;
  logic [DATA_W-1:0]     rdata;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      cap_idx;
  logic                  cap;
  logic                  err;
  logic [PIDX_W-1:0]     pidx;

  assign pidx = PIDX_W'(addr >> PAGE_OFFSET_BITS);

  always_ff @(posedge clk) begin
    if (cmd.step && (op == OP_WRITE)) begin
      mem[addr] <= wdata[BYTE_W-1:0];
    end
    if (cmd.step && (op == OP_READ)) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      cap        <= 1'b0;
    end else begin
      cap <= cmd.step && (op == OP_READ);
      if (cmd.step && (op == OP_WRITE)) begin
        page_valid[pidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= idx;
    if (cmd.load) begin
      op    <= opcode;
      addr  <= ADDR_W'(byte_address);
      wdata <= write_data;
      idx   <= '0;
      rdata <= '0;
      err   <= 1'b0;
    end else begin
      if (cmd.step) begin
        addr  <= addr + ADDR_W'(1);
        wdata <= wdata >> BYTE_W;
        idx   <= idx + IDX_W'(1);
        if (op == OP_READ) begin
          err <= err | !page_valid[pidx];
        end
      end
      if (cap) begin
        rdata[BYTE_W*cap_idx +: BYTE_W] <= mem_q;
      end
    end
    if (cmd.finish) begin
      read_data  <= ((op == OP_READ) && !err) ? rdata : '0;
      page_error <= (op == OP_READ) && err;
    end
  end

  `PBMA_ASSERT_IMP(a_error_zero_data, page_error, read_data == '0, "error result carries data")
  `PBMA_ASSERT_NXT(a_write_no_error, cmd.finish && (op == OP_WRITE), !page_error, "write flagged an error")
  `PBMA_ASSERT_IMP(a_load_not_step, cmd.load, !cmd.step, "load and byte step in one cycle")

endmodule

@@ rtl/core/paged_byte_memory_multibyte_access_top.sv @@
// Top level of the paged little-endian byte memory.
// An access of n bytes (n = num_bytes, cut to MAX_BYTES) goes from its input transfer to its
// result being ready in these steps: the transfer is taken, one byte per cycle passes
// through the single port of the byte store, the last read byte returns, and the result
// register is loaded. One access is in progress at a time, and a finished result
// waits in its own register while the next access runs. Page valid bits clear at reset and need
// no clearing pass; the byte store is not cleared, so only bytes written before can be read.
`include "paged_byte_memory_multibyte_access_top_macros.svh"
module paged_byte_memory_multibyte_access_top #(
  parameter int ADDR_W           = 16,
  parameter int PAGE_OFFSET_BITS = 8,
  parameter int MAX_BYTES        = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [15:0]                 byte_address,
  input  logic [pbma_pkg::LEN_W-1:0]  num_bytes,
  input  logic [pbma_pkg::DATA_W-1:0] write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbma_pkg::DATA_W-1:0] read_data,
  output logic                        page_error
);
  import pbma_pkg::*;

  cmd_t cmd;

  pbma_ctrl #(
    .MAX_BYTES(MAX_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .num_bytes(num_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  pbma_datapath #(
    .ADDR_W          (ADDR_W),
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
    .MAX_BYTES       (MAX_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .byte_address(byte_address),
    .write_data  (write_data),
    .read_data   (read_data),
    .page_error  (page_error)
  );

endmodule

@@ test/paged_byte_memory_multibyte_access_top_test.sv @@
// Randomized self-checking testbench for the paged little-endian byte memory.
`timescale 1ns / 100ps

module paged_byte_memory_multibyte_access_top_test;
  import pbma_pkg::*;

  localparam int MAX_BYTES      = 8;
  localparam int PAGE_SHIFT     = 8;
  localparam int RANDOM_ITEMS   = 650;
  localparam int RECENT_DEPTH   = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic              op;
    logic [15:0]       addr;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } access_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              err;
  } read_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = OP_READ;
  logic [15:0]       byte_address = '0;
  logic [LEN_W-1:0]  num_bytes = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic              page_error;

  access_t      pending_accesses[$];
  read_result_t expected_reads[$];

  // Predictor state, updated at each accepted input transfer.
  logic [7:0] mem_bytes [0:65535];
  bit         page_ok   [0:255];

  // Stimulus-side shadow, so that no read touches an unwritten byte of a valid page.
  bit          gen_written [0:65535];
  bit          gen_page    [0:255];
  logic [15:0] recent_addr[$];
  int          recent_len[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int n_writes = 0;
  int n_good_reads = 0;
  int n_err_reads = 0;
  int n_results = 0;
  bit in_fire = 1'b0;
  int in_gap = 0;
  bit in_burst = 1'b0;
  int out_hold = 0;
  bit out_burst = 1'b0;
  bit nxt_valid;
  bit nxt_stall;
  access_t      drv_item;
  access_t      mon_item;
  read_result_t got_res;
  read_result_t want_res;

  paged_byte_memory_multibyte_access_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .byte_address (byte_address),
    .num_bytes    (num_bytes),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .page_error   (page_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int eff_len(logic [LEN_W-1:0] n);
    return (n > MAX_BYTES) ? MAX_BYTES : int'(n);
  endfunction

  function automatic bit read_is_safe(logic [15:0] addr, logic [LEN_W-1:0] n);
    logic [15:0] a;
    for (int k = 0; k < eff_len(n); k++) begin
      a = addr + 16'(k);
      if (gen_page[a >> PAGE_SHIFT] && !gen_written[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return LEN_W'($urandom_range(1, MAX_BYTES));
    if (r < 90) return '0;
    return LEN_W'($urandom_range(MAX_BYTES + 1, 15));
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic queue_access(logic op, logic [15:0] addr, logic [LEN_W-1:0] n,
                              logic [DATA_W-1:0] data);
    access_t     acc;
    logic [15:0] a;
    acc.op   = op;
    acc.addr = addr;
    acc.len  = n;
    acc.data = data;
    pending_accesses.push_back(acc);
    if (op == OP_WRITE && eff_len(n) > 0) begin
      for (int k = 0; k < eff_len(n); k++) begin
        a = addr + 16'(k);
        gen_written[a] = 1'b1;
        gen_page[a >> PAGE_SHIFT] = 1'b1;
      end
      recent_addr.push_back(addr);
      recent_len.push_back(eff_len(n));
      if (recent_addr.size() > RECENT_DEPTH) begin
        void'(recent_addr.pop_front());
        void'(recent_len.pop_front());
      end
    end
  endtask

  task automatic queue_random_access();
    logic [15:0]      addr;
    logic [LEN_W-1:0] n;
    int               pick;
    int               r;
    bit               safe;
    if ($urandom_range(0, 1) == 1) begin
      r = $urandom_range(0, 9);
      if (r < 4)      addr = 16'($urandom_range(0, 16'h01FF));
      else if (r < 6) addr = 16'hFF00 + 16'($urandom_range(0, 16'hFF));
      else if (r < 8) addr = 16'h80F0 + 16'($urandom_range(0, 16'h1F));
      else            addr = 16'($urandom);
      queue_access(OP_WRITE, addr, rand_len(), {$urandom, $urandom});
    end else begin
      safe = 1'b0;
      for (int t = 0; t < 8 && !safe; t++) begin
        if ($urandom_range(0, 3) != 0 && recent_addr.size() > 0) begin
          pick = $urandom_range(0, recent_addr.size() - 1);
          addr = recent_addr[pick] + 16'($urandom_range(0, recent_len[pick]))
                 - 16'($urandom_range(0, 3));
        end else begin
          addr = 16'($urandom);
        end
        n = rand_len();
        safe = read_is_safe(addr, n);
      end
      if (!safe) begin
        pick = $urandom_range(0, recent_addr.size() - 1);
        addr = recent_addr[pick];
        n    = LEN_W'(recent_len[pick]);
      end
      queue_access(OP_READ, addr, n, {$urandom, $urandom});
    end
  endtask

  task automatic predict_access(input access_t acc, output read_result_t res);
    logic [15:0] a;
    res.data = '0;
    res.err  = 1'b0;
    for (int k = 0; k < eff_len(acc.len); k++) begin
      a = acc.addr + 16'(k);
      if (acc.op == OP_WRITE) begin
        mem_bytes[a] = acc.data[BYTE_W*k +: BYTE_W];
        page_ok[a >> PAGE_SHIFT] = 1'b1;
      end else begin
        if (!page_ok[a >> PAGE_SHIFT]) res.err = 1'b1;
        res.data[BYTE_W*k +: BYTE_W] = mem_bytes[a];
      end
    end
    if (res.err) res.data = '0;
    if (acc.op == OP_WRITE) n_writes++;
    else if (res.err) n_err_reads++;
    else n_good_reads++;
  endtask

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Input side: one access at a time from the pending queue, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_accesses.size() > 0) begin
        drv_item = pending_accesses.pop_front();
        opcode       <= drv_item.op;
        byte_address <= drv_item.addr;
        num_bytes    <= drv_item.len;
        write_data   <= drv_item.data;
        nxt_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = pick_gap(in_burst);
      end
      in_valid <= nxt_valid;
    end
  end

  // Output side: random stall, with occasional stretches of none.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      nxt_stall = 1'b0;
      if (out_hold > 0) begin
        out_hold--;
        nxt_stall = 1'b1;
      end else if (!out_burst && $urandom_range(0, 99) >= 55) begin
        nxt_stall = 1'b1;
        out_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
      end
      if ($urandom_range(0, 99) == 0) out_burst = !out_burst;
      out_stall <= nxt_stall;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
      idle_cycles = 0;
      foreach (page_ok[i]) page_ok[i] = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        mon_item.op   = opcode;
        mon_item.addr = byte_address;
        mon_item.len  = num_bytes;
        mon_item.data = write_data;
        predict_access(mon_item, want_res);
        expected_reads.push_back(want_res);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        got_res.data = read_data;
        got_res.err  = page_error;
        if (expected_reads.size() == 0) begin
          report_mismatch("unexpected result", got_res.data, '0);
        end else begin
          want_res = expected_reads.pop_front();
          if (got_res.data !== want_res.data)
            report_mismatch("read_data", got_res.data, want_res.data);
          if (got_res.err !== want_res.err)
            report_mismatch("page_error", DATA_W'(got_res.err), DATA_W'(want_res.err));
        end
      end
      if (in_fire || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("** paged_byte_memory_multibyte_access_top: FAILED **");
    $finish;
  end

  initial begin
    queue_access(OP_READ,  16'h0000, 4'd8,  64'h0);
    queue_access(OP_READ,  16'h1234, 4'd0,  64'h0);
    queue_access(OP_WRITE, 16'h0000, 4'd8,  64'h0123_4567_89AB_CDEF);
    queue_access(OP_READ,  16'h0000, 4'd8,  64'h0);
    queue_access(OP_READ,  16'h0003, 4'd1,  64'h0);
    queue_access(OP_READ,  16'h0002, 4'd4,  64'h0);
    queue_access(OP_WRITE, 16'hFFFC, 4'd8,  64'hFEDC_BA98_7654_3210);
    queue_access(OP_READ,  16'hFFFC, 4'd8,  64'h0);
    queue_access(OP_READ,  16'hFFFE, 4'd4,  64'h0);
    queue_access(OP_WRITE, 16'h5000, 4'd0,  '1);
    queue_access(OP_READ,  16'h5000, 4'd1,  '1);
    queue_access(OP_WRITE, 16'h1000, 4'd15, '1);
    queue_access(OP_READ,  16'h1000, 4'd12, '1);
    queue_access(OP_WRITE, 16'h20F8, 4'd8,  64'h0);
    queue_access(OP_READ,  16'h20FC, 4'd8,  64'h0);
    queue_access(OP_WRITE, 16'h30FD, 4'd6,  {$urandom, $urandom});
    queue_access(OP_READ,  16'h30FD, 4'd6,  64'h0);
    queue_access(OP_READ,  16'h30FF, 4'd2,  64'h0);
    queue_access(OP_WRITE, 16'hFFFF, 4'd1,  64'hA5);
    queue_access(OP_READ,  16'hFFFF, 4'd1,  64'h0);
    queue_access(OP_READ,  16'hFFFF, 4'd9,  64'h0);
    queue_access(OP_WRITE, 16'h4000, 4'd8,  64'h8000_0000_0000_0001);
    queue_access(OP_READ,  16'h4000, 4'd8,  '1);
    for (int i = 0; i < RANDOM_ITEMS; i++) queue_random_access();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_accesses.size() != 0 || in_valid) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d accesses: %0d writes, %0d good reads, %0d page-error reads.",
             n_writes + n_good_reads + n_err_reads, n_writes, n_good_reads, n_err_reads);
    $display("Checked %0d results with address wrap, page crossing and clipped lengths; %0d mismatches.",
             n_results, mismatches);
    if (mismatches == 0) begin
      $display("** paged_byte_memory_multibyte_access_top: PASSED **");
    end else begin
      $display("** paged_byte_memory_multibyte_access_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pbma_pkg.sv
rtl/core/pbma_ctrl.sv
rtl/core/pbma_datapath.sv
rtl/core/paged_byte_memory_multibyte_access_top.sv
test/paged_byte_memory_multibyte_access_top_test.sv
